>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define CHK_HOLDS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("check failed");

// Antecedent at one edge implies consequent at the next edge.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Types, codes and helpers for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int MaxLengthBytesDef = 4;
  localparam int DeltaBytes        = 4;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_LEN       = 4'd5,
    PH_FIXED     = 4'd6,
    PH_STREAM    = 4'd7,
    PH_SYSEX     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    K_CHANNEL = 3'd0,
    K_SYSTEM  = 3'd1,
    K_META    = 3'd2,
    K_SYSEX   = 3'd3,
    K_PAYLOAD = 3'd4,
    K_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE      = 2'd0,
    E_INVALID   = 2'd1,
    E_BAD_LEN   = 2'd2,
    E_TRUNCATED = 2'd3
  } err_t;

  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_ESCAPE = 8'hF7;
  localparam logic [7:0] ST_META   = 8'hFF;
  localparam logic [27:0] Mask28   = 28'hFFF_FFFF;

  typedef struct packed {
    logic        track_last;
    logic [7:0]  byte_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [27:0] delta_ticks;
    logic [31:0] absolute_ticks;
    logic [39:0] meta_value;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  error_code;
  } out_word_t;

  // 0 text-like, 1 fixed valid, 2 fixed bad length
  function automatic logic [1:0] meta_form(input logic [6:0] t, input logic [27:0] len);
    logic [1:0] f;
    case (t)
      7'h00:   f = (len == 28'd0 || len == 28'd2) ? 2'd1 : 2'd2;
      7'h20:   f = (len == 28'd1) ? 2'd1 : 2'd2;
      7'h2F:   f = (len == 28'd0) ? 2'd1 : 2'd2;
      7'h51:   f = (len == 28'd3) ? 2'd1 : 2'd2;
      7'h54:   f = (len == 28'd5) ? 2'd1 : 2'd2;
      7'h58:   f = (len == 28'd4) ? 2'd1 : 2'd2;
      7'h59:   f = (len == 28'd2) ? 2'd1 : 2'd2;
      default: f = 2'd0;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] data_needed(input logic [7:0] st);
    logic [1:0] n;
    if (st == 8'hF2) n = 2'd2;
    else if (st == 8'hF1 || st == 8'hF3) n = 2'd1;
    else if (st >= 8'hF0) n = 2'd0;
    else if (st[7:4] == 4'hC || st[7:4] == 4'hD) n = 2'd1;
    else n = 2'd2;
    return n;
  endfunction

endpackage

>>> rtl/mtep_if.sv
// ----------------------------------------------------------------------------
// mtep_in_if / mtep_out_if
// Valid/ready channels carrying parser input and result words.
// ----------------------------------------------------------------------------
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       track_last;
  modport source (output valid, byte_in, track_last, input ready);
  modport sink   (input valid, byte_in, track_last, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  status_byte;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [27:0] delta_ticks;
  logic [31:0] absolute_ticks;
  logic [39:0] meta_value;
  logic [27:0] payload_length;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [1:0]  error_code;
  modport source (output valid, kind, status_byte, first_data, second_data, delta_ticks,
                  absolute_ticks, meta_value, payload_length, payload_byte, payload_last,
                  error_code, input ready);
  modport sink   (input valid, kind, status_byte, first_data, second_data, delta_ticks,
                  absolute_ticks, meta_value, payload_length, payload_byte, payload_last,
                  error_code, output ready);
endinterface

>>> rtl/mtep_core.sv
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and per-byte next-state/result logic.
// ----------------------------------------------------------------------------
module mtep_core
  import mtep_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MaxLengthBytesDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_word_t  in_word,
  output logic      res_valid,
  output out_word_t res
);

  phase_t      parse_phase, parse_phase_next;
  logic [27:0] length_accumulator, length_accumulator_next;
  logic [2:0]  length_byte_count, length_byte_count_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  current_status, current_status_next;
  logic [6:0]  held_first_data, held_first_data_next;
  logic [27:0] delta_held, delta_held_next;
  logic [31:0] tick_sum, tick_sum_next;
  logic [27:0] payload_remaining, payload_remaining_next;
  logic [39:0] meta_accumulator, meta_accumulator_next;
  logic        skip_to_track_end, skip_next;

  logic [7:0]  b;
  logic [27:0] vlq_acc;
  logic [2:0]  vlq_cnt;
  logic [27:0] rem_dec;
  logic [7:0]  st_eff;
  logic        err_hit;
  logic        err_word;

  assign b = in_word.byte_in;
  assign vlq_acc = {length_accumulator[20:0], b[6:0]};
  assign vlq_cnt = length_byte_count + 3'd1;
  assign rem_dec = (payload_remaining != 28'd0) ? payload_remaining - 28'd1 : 28'd0;

  always_comb begin
    parse_phase_next        = parse_phase;
    length_accumulator_next = length_accumulator;
    length_byte_count_next  = length_byte_count;
    running_status_next     = running_status;
    current_status_next     = current_status;
    held_first_data_next    = held_first_data;
    delta_held_next         = delta_held;
    tick_sum_next           = tick_sum;
    payload_remaining_next  = payload_remaining;
    meta_accumulator_next   = meta_accumulator;
    skip_next               = skip_to_track_end;
    res_valid = 1'b0;
    res = '0;
    err_hit = 1'b0;
    st_eff = 8'd0;

    if (!skip_to_track_end) begin
      case (parse_phase)
        PH_DELTA: begin
          if (length_accumulator[27:21] != 7'd0) begin
            err_hit = 1'b1; res.error_code = E_BAD_LEN;
          end else begin
            length_accumulator_next = vlq_acc;
            length_byte_count_next = vlq_cnt;
            if (!b[7]) begin
              length_byte_count_next = 3'd0;
              delta_held_next = vlq_acc;
              tick_sum_next = tick_sum + {4'd0, vlq_acc};
              length_accumulator_next = 28'd0;
              parse_phase_next = PH_STATUS;
            end else if (vlq_cnt >= 3'(DeltaBytes)) begin
              err_hit = 1'b1; res.error_code = E_BAD_LEN;
            end
          end
        end
        PH_STATUS, PH_DATA1: begin
          if (parse_phase == PH_STATUS && b[7]) begin
            if (b < 8'hF0) begin
              current_status_next = b; running_status_next = b;
              parse_phase_next = PH_DATA1;
            end else if (b == ST_SYSEX) begin
              running_status_next = 8'd0; current_status_next = b;
              length_accumulator_next = 28'd0; parse_phase_next = PH_SYSEX;
              res_valid = 1'b1; res.kind = K_SYSEX; res.status_byte = ST_SYSEX;
            end else if (b == ST_ESCAPE) begin
              running_status_next = 8'd0; current_status_next = b;
              length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
              parse_phase_next = PH_LEN;
            end else if (b == ST_META) begin
              running_status_next = 8'd0; current_status_next = b;
              parse_phase_next = PH_META_TYPE;
            end else if (b <= 8'hF6) begin
              running_status_next = 8'd0; current_status_next = b;
              if (data_needed(b) == 2'd0) begin
                res_valid = 1'b1; res.kind = K_SYSTEM; res.status_byte = b;
                parse_phase_next = PH_DELTA;
                length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
              end else begin
                parse_phase_next = PH_DATA1;
              end
            end else begin
              err_hit = 1'b1; res.error_code = E_INVALID;
            end
          end else if (parse_phase == PH_STATUS && running_status == 8'd0) begin
            err_hit = 1'b1; res.error_code = E_INVALID;
          end else if (b[7]) begin
            err_hit = 1'b1; res.error_code = E_INVALID;
          end else begin
            st_eff = (parse_phase == PH_STATUS) ? running_status : current_status;
            current_status_next = st_eff;
            held_first_data_next = b[6:0];
            if (data_needed(st_eff) == 2'd1) begin
              res_valid = 1'b1;
              res.kind = (st_eff < 8'hF0) ? K_CHANNEL : K_SYSTEM;
              res.status_byte = st_eff; res.first_data = b[6:0];
              parse_phase_next = PH_DELTA;
              length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
            end else begin
              parse_phase_next = PH_DATA2;
            end
          end
        end
        PH_DATA2: begin
          if (b[7]) begin
            err_hit = 1'b1; res.error_code = E_INVALID;
          end else begin
            res_valid = 1'b1;
            res.kind = (current_status < 8'hF0) ? K_CHANNEL : K_SYSTEM;
            res.status_byte = current_status;
            res.first_data = held_first_data; res.second_data = b[6:0];
            parse_phase_next = PH_DELTA;
            length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
          end
        end
        PH_META_TYPE: begin
          if (b[7]) begin
            err_hit = 1'b1; res.error_code = E_INVALID;
          end else begin
            held_first_data_next = b[6:0];
            length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
            parse_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (length_accumulator[27:21] != 7'd0) begin
            err_hit = 1'b1; res.error_code = E_BAD_LEN;
          end else begin
            length_accumulator_next = vlq_acc;
            length_byte_count_next = vlq_cnt;
            if (b[7]) begin
              if (vlq_cnt >= 3'(MAX_LENGTH_BYTES)) begin
                err_hit = 1'b1; res.error_code = E_BAD_LEN;
              end
            end else begin
              length_byte_count_next = 3'd0;
              payload_remaining_next = vlq_acc;
              if (current_status == ST_ESCAPE) begin
                res_valid = 1'b1; res.kind = K_SYSEX; res.status_byte = ST_ESCAPE;
                res.payload_length = vlq_acc;
                parse_phase_next = (vlq_acc != 28'd0) ? PH_STREAM : PH_DELTA;
              end else begin
                case (meta_form(held_first_data, vlq_acc))
                  2'd2: begin
                    err_hit = 1'b1; res.error_code = E_BAD_LEN;
                  end
                  2'd1: begin
                    meta_accumulator_next = 40'd0;
                    if (vlq_acc == 28'd0) begin
                      res_valid = 1'b1; res.kind = K_META;
                      res.status_byte = {1'b0, held_first_data};
                      parse_phase_next = PH_DELTA;
                    end else begin
                      parse_phase_next = PH_FIXED;
                    end
                  end
                  default: begin
                    meta_accumulator_next = 40'd0;
                    res_valid = 1'b1; res.kind = K_META;
                    res.status_byte = {1'b0, held_first_data};
                    res.payload_length = vlq_acc;
                    parse_phase_next = (vlq_acc != 28'd0) ? PH_STREAM : PH_DELTA;
                  end
                endcase
              end
              if (!err_hit && parse_phase_next == PH_DELTA) begin
                length_accumulator_next = 28'd0;
              end
            end
          end
        end
        PH_FIXED: begin
          meta_accumulator_next = {meta_accumulator[31:0], b};
          payload_remaining_next = rem_dec;
          if (rem_dec == 28'd0) begin
            res_valid = 1'b1; res.kind = K_META;
            res.status_byte = {1'b0, held_first_data};
            res.meta_value = {meta_accumulator[31:0], b};
            res.payload_length = length_accumulator;
            parse_phase_next = PH_DELTA;
            length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
          end
        end
        PH_STREAM: begin
          payload_remaining_next = rem_dec;
          res_valid = 1'b1; res.kind = K_PAYLOAD;
          res.status_byte = (current_status == ST_META) ? {1'b0, held_first_data}
                                                         : current_status;
          res.payload_length = length_accumulator - rem_dec;
          res.payload_byte = b;
          res.payload_last = (rem_dec == 28'd0);
          if (rem_dec == 28'd0) begin
            parse_phase_next = PH_DELTA;
            length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
          end
        end
        PH_SYSEX: begin
          length_accumulator_next = (length_accumulator != Mask28) ?
                                    length_accumulator + 28'd1 : length_accumulator;
          res_valid = 1'b1; res.kind = K_PAYLOAD; res.status_byte = ST_SYSEX;
          res.payload_length = length_accumulator_next;
          res.payload_byte = b; res.payload_last = b[7];
          if (b[7]) begin
            parse_phase_next = PH_DELTA;
            length_accumulator_next = 28'd0; length_byte_count_next = 3'd0;
          end
        end
        default: begin
          err_hit = 1'b1; res.error_code = E_INVALID;
        end
      endcase

      if (err_hit) begin
        res_valid = 1'b1;
        res.kind = K_ERROR;
        res.status_byte = 8'd0; res.first_data = 7'd0; res.second_data = 7'd0;
        res.meta_value = 40'd0; res.payload_length = 28'd0;
        res.payload_byte = 8'd0; res.payload_last = 1'b0;
        skip_next = 1'b1;
      end
      res.delta_ticks = delta_held_next;
      res.absolute_ticks = tick_sum_next;
      if (in_word.track_last && !err_hit &&
          (parse_phase_next != PH_DELTA || length_byte_count_next != 3'd0)) begin
        res_valid = 1'b1;
        res = '0;
        res.kind = K_ERROR;
        res.error_code = E_TRUNCATED;
        res.delta_ticks = delta_held_next;
        res.absolute_ticks = tick_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_word.track_last)) begin
      parse_phase        <= PH_DELTA;
      length_accumulator <= '0;
      length_byte_count  <= '0;
      running_status     <= '0;
      current_status     <= '0;
      held_first_data    <= '0;
      delta_held         <= '0;
      tick_sum           <= '0;
      payload_remaining  <= '0;
      meta_accumulator   <= '0;
      skip_to_track_end  <= 1'b0;
    end else if (step) begin
      parse_phase        <= parse_phase_next;
      length_accumulator <= length_accumulator_next;
      length_byte_count  <= length_byte_count_next;
      running_status     <= running_status_next;
      current_status     <= current_status_next;
      held_first_data    <= held_first_data_next;
      delta_held         <= delta_held_next;
      tick_sum           <= tick_sum_next;
      payload_remaining  <= payload_remaining_next;
      meta_accumulator   <= meta_accumulator_next;
      skip_to_track_end  <= skip_next;
    end
  end

  assign err_word = step && res_valid && res.kind == K_ERROR && !in_word.track_last;

  `include "assert_macros.svh"

  `CHK_NEXT(a_err_skips, err_word, skip_to_track_end)
  `CHK_HOLDS(a_skip_silent, !(skip_to_track_end && res_valid))
  `CHK_NEXT(a_last_clears, step && in_word.track_last, parse_phase == PH_DELTA && !skip_to_track_end)

endmodule

>>> rtl/mtep_out_reg.sv
// ----------------------------------------------------------------------------
// mtep_out_reg
// Two-entry skid buffer holding result words for the output channel.
// ----------------------------------------------------------------------------
module mtep_out_reg
  import mtep_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_word,
  output logic      has_room,
  input  logic      pop,
  output logic      head_valid,
  output out_word_t head_word
);

  out_word_t slot0, slot1;
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign head_word  = slot0;
  assign has_room   = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : push_word;
      if (push) slot1 <= push_word;
    end else if (push) begin
      if (count == 2'd0) slot0 <= push_word;
      else slot1 <= push_word;
    end
  end

  `include "assert_macros.svh"

  `CHK_HOLDS(a_no_overflow, !(push && !pop && count == 2'd2))
  `CHK_HOLDS(a_no_underflow, !(pop && count == 2'd0))

endmodule

>>> rtl/midi_track_event_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// MIDI track chunk parser: one byte in, at most one event word out.
// ----------------------------------------------------------------------------
// Takes one track byte per cycle and writes its result word into the output
// buffer on acceptance, so throughput is one byte per clock while the output
// side keeps up. A two-word skid buffer between the parser state logic and
// the output channel lets input keep flowing when the sink stalls; input
// ready drops only while both buffer entries are occupied.
module midi_track_event_parser_unit
  import mtep_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MaxLengthBytesDef
) (
  input logic        clk,
  input logic        rst,
  mtep_in_if.sink    in_ch,
  mtep_out_if.source out_ch
);

  in_word_t  in_word;
  out_word_t res, head;
  logic      res_valid, step, room, head_valid, pop;

  assign in_word.byte_in    = in_ch.byte_in;
  assign in_word.track_last = in_ch.track_last;
  assign in_ch.ready = room;
  assign step = in_ch.valid && room;
  assign pop  = head_valid && out_ch.ready;

  mtep_core #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_core (
    .clk, .rst, .step, .in_word, .res_valid, .res
  );

  mtep_out_reg u_out (
    .clk, .rst,
    .push(step && res_valid), .push_word(res), .has_room(room),
    .pop, .head_valid, .head_word(head)
  );

  assign out_ch.valid          = head_valid;
  assign out_ch.kind           = head.kind;
  assign out_ch.status_byte    = head.status_byte;
  assign out_ch.first_data     = head.first_data;
  assign out_ch.second_data    = head.second_data;
  assign out_ch.delta_ticks    = head.delta_ticks;
  assign out_ch.absolute_ticks = head.absolute_ticks;
  assign out_ch.meta_value     = head.meta_value;
  assign out_ch.payload_length = head.payload_length;
  assign out_ch.payload_byte   = head.payload_byte;
  assign out_ch.payload_last   = head.payload_last;
  assign out_ch.error_code     = head.error_code;

endmodule
